// ===== sv/match_countdown_timer_control_top_macros.svh =====
// Assertion macros for the match countdown timer control block.
// Included by modules that check their own logic; no other dependencies.
`ifndef MATCH_COUNTDOWN_TIMER_CONTROL_TOP_MACROS_SVH
`define MATCH_COUNTDOWN_TIMER_CONTROL_TOP_MACROS_SVH

// Checked at every rising clock edge, skipped while reset is high.
`define MCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define MCT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== sv/mct_pkg.sv =====
// Shared types and constants for the match countdown timer control block.
// No dependencies.
`default_nettype none

package mct_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned CSR_IDX_W = 8;

   localparam logic [TIME_W-1:0] ONE_SECOND_MS = 32'd1000;
   localparam logic [TIME_W-1:0] SUB15_MS      = 32'd15000;
   localparam logic [TIME_W-1:0] ADD30_MS      = 32'd30000;
   localparam logic [TIME_W-1:0] ADD60_MS      = 32'd60000;

   localparam logic [TIME_W-1:0]  MATCH_TIME_RESET = 32'd120000;
   localparam logic [COUNT_W-1:0] COUNTDOWN_RESET  = 8'd5;

   localparam logic [CSR_IDX_W-1:0] REG_MATCH_TIME = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COUNTDOWN  = 8'd1;

   typedef enum logic [1:0] {
      MODE_PAUSED = 2'd0,
      MODE_COUNT  = 2'd1,
      MODE_RUN    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      LED_NONE  = 2'd0,
      LED_WRITE = 2'd1,
      LED_CLEAR = 2'd2
   } led_action_type;

   // first field in the highest bits, last field in the lowest bits
   typedef struct packed {
      logic              pad;
      logic              sub15_press;
      logic              add60_press;
      logic              add30_press;
      logic              pause_press;
      logic              resume_press;
      logic              remote_start;
      logic              start_press;
      logic [TIME_W-1:0] now_ms;
   } req_data_type;

   typedef struct packed {
      logic [3:0]         pad;
      logic [COUNT_W-1:0] led_value;
      led_action_type     led_action;
      logic [TIME_W-1:0]  display_ms;
      mode_type           mode;
   } rsp_data_type;

endpackage

`default_nettype wire

// ===== sv/match_countdown_timer_control_top.sv =====
// Top level of the match countdown timer control block: mode logic, state and result register.
// Depends on mct_pkg and match_countdown_timer_control_top_macros.svh.
//
// Usage:
//   req_* carries one control tick per transfer: a millisecond timestamp and
//   one-shot button flags. rsp_* returns exactly one result per tick: mode,
//   display time and the LED action. csr_* writes the match time (index 0,
//   also reloads the target) and the LED countdown start (index 1, also
//   reloads the count); csr_ready is always high. The user must make writes
//   only while idle; the block does not enforce this. The result of a tick is
//   registered onto rsp_* in the cycle after its transfer. One tick per cycle
//   while the receiver takes results; the whole update is one combinational
//   pass from the state registers into the result register.
//   When the receiver stalls, the result register holds and req_tready drops
//   until the result is taken; req_tready stays high while rsp_tready is high.
//   Reset: mode paused, target = 120000 ms, count = 5, timestamps zero, no
//   result pending.
`default_nettype none
`include "match_countdown_timer_control_top_macros.svh"

module match_countdown_timer_control_top
   import mct_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // tdata: now_ms[31:0], start_press[32], remote_start[33], resume_press[34],
   //        pause_press[35], add30_press[36], add60_press[37], sub15_press[38], zero[39]
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [39:0]          req_tdata,
   // tdata: mode[1:0], display_ms[33:2], led_action[35:34], led_value[43:36], zero[47:44]
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [47:0]               rsp_tdata,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TIME_W-1:0]    csr_data
);

   req_data_type req;
   logic         req_accept;
   logic         csr_write;
   logic         start;

   mode_type           mode_ff, mode_in;
   logic [TIME_W-1:0]  target_ff, target_in;
   logic [TIME_W-1:0]  run_start_ff, run_start_in;
   logic [TIME_W-1:0]  interval_ff, interval_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_start_ff;

   logic                rsp_valid_ff;
   rsp_data_type        rsp_ff, rsp_in;

   logic [TIME_W-1:0] run_elapsed;
   logic [TIME_W-1:0] since_tick;
   logic [TIME_W-1:0] adjust;
   logic [TIME_W-1:0] target_adj;

   assign req        = req_data_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid;
   assign start      = req.start_press || req.remote_start;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // net target change from the adjust buttons, mod 2^32
   always_comb begin
      adjust = '0;
      if (req.add30_press) adjust = adjust + ADD30_MS;
      if (req.add60_press) adjust = adjust + ADD60_MS;
      if (req.sub15_press) adjust = adjust - SUB15_MS;
   end

   always_comb begin
      mode_in      = mode_ff;
      target_in    = target_ff;
      run_start_in = run_start_ff;
      interval_in  = interval_ff;
      count_in     = count_ff;
      rsp_in       = '0;
      rsp_in.led_action = LED_NONE;

      unique case (mode_ff)
         MODE_PAUSED: begin
            if (start) begin
               mode_in     = MODE_COUNT;
               interval_in = req.now_ms;
            end else if (req.resume_press) begin
               mode_in      = MODE_RUN;
               run_start_in = req.now_ms;
            end
         end
         MODE_COUNT: begin
            if (req.pause_press) begin
               mode_in           = MODE_PAUSED;
               rsp_in.led_action = LED_CLEAR;
               count_in          = count_start_ff;
            end else if (count_ff == '0) begin
               mode_in      = MODE_RUN;
               run_start_in = req.now_ms;
            end
         end
         default: begin
            // running; an unused code behaves the same
            if (req.pause_press) begin
               mode_in   = MODE_PAUSED;
               target_in = target_ff - (req.now_ms - run_start_ff);
            end
         end
      endcase

      since_tick = req.now_ms - interval_in;
      if (mode_in == MODE_COUNT) begin
         if (since_tick >= ONE_SECOND_MS) begin
            count_in    = count_in - COUNT_W'(1);
            interval_in = req.now_ms;
         end
         rsp_in.led_action = LED_WRITE;
         rsp_in.led_value  = count_in;
      end

      target_adj  = target_in + adjust;
      target_in   = target_adj;
      run_elapsed = req.now_ms - run_start_in;
      rsp_in.mode = mode_in;
      rsp_in.display_ms = (mode_in == MODE_RUN) ? target_adj - run_elapsed : target_adj;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_PAUSED;
         target_ff      <= MATCH_TIME_RESET;
         run_start_ff   <= '0;
         interval_ff    <= '0;
         count_ff       <= COUNTDOWN_RESET;
         count_start_ff <= COUNTDOWN_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            mode_ff      <= mode_in;
            target_ff    <= target_in;
            run_start_ff <= run_start_in;
            interval_ff  <= interval_in;
            count_ff     <= count_in;
         end
         // register writes must be made by the user only while idle; the block does not enforce this
         if (csr_write && csr_index == REG_MATCH_TIME) begin
            target_ff <= csr_data;
         end
         if (csr_write && csr_index == REG_COUNTDOWN) begin
            count_start_ff <= csr_data[COUNT_W-1:0];
            count_ff       <= csr_data[COUNT_W-1:0];
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   `MCT_ASSERT_ALWAYS(a_reset_paused, reset |=> (mode_ff == MODE_PAUSED && !rsp_valid_ff), "reset must leave block paused and empty")
   `MCT_ASSERT(a_mode_only_on_transfer, !req_accept |=> $stable(mode_ff), "mode changed without an input transfer")
   `MCT_ASSERT(a_rsp_mode_matches, rsp_valid_ff |-> (rsp_ff.mode == mode_ff), "result mode differs from state")
   `MCT_ASSERT(a_led_write_in_count, rsp_valid_ff |-> ((rsp_ff.led_action == LED_WRITE) == (rsp_ff.mode == MODE_COUNT)), "LED write without countdown mode")
   `MCT_ASSERT(a_led_value_idle, (rsp_valid_ff && rsp_ff.led_action != LED_WRITE) |-> (rsp_ff.led_value == '0), "LED value set without write")

endmodule

`default_nettype wire
